>>> rtl/core/raw_gm_pkg.sv
// shared constants, register indexes and pipeline word type for the raw gain map
package raw_gm_pkg;

   // grid and gain format
   localparam int GRID_ROWS      = 64;
   localparam int GRID_COLS      = 64;
   localparam int GAIN_FRAC_BITS = 12;

   localparam int ROW_W  = $clog2(GRID_ROWS);
   localparam int COL_W  = $clog2(GRID_COLS);
   localparam int ADDR_W = $clog2(GRID_ROWS * GRID_COLS);
   localparam int DEPTH  = GRID_ROWS * GRID_COLS;

   // field widths
   localparam int GIDX_W = 6;
   localparam int POS_W  = 16;
   localparam int SMP_W  = 16;
   localparam int GAIN_W = 16;
   localparam int SCL_W  = 24;
   localparam int CSR_W  = 24;
   localparam int CSR_A  = 3;

   // derived arithmetic widths
   localparam int PROD_W = POS_W + SCL_W;          // grid position product
   localparam int HOR_W  = GAIN_W + SCL_W;         // one interpolated row
   localparam int DL_W   = 20;                     // low part of row difference
   localparam int DH_W   = HOR_W + 1 - DL_W;       // signed high part
   localparam int PH_W   = DH_W + SCL_W + 1;
   localparam int PL_W   = DL_W + SCL_W;
   localparam int SUM_W  = HOR_W + SCL_W + 2;
   localparam int G_W    = 32;
   localparam int MUL_W  = SMP_W + G_W;
   localparam int RND_SH = GAIN_FRAC_BITS + 16;

   // remainder pipeline for the pitch lattice test
   localparam int DIV_STEPS = POS_W;
   localparam int NST       = DIV_STEPS + 2;

   // word packing
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 24;

   // configuration register indexes
   typedef enum logic [CSR_A-1:0] {
      REG_LEFT      = 3'd0,
      REG_RIGHT     = 3'd1,
      REG_TOP       = 3'd2,
      REG_BOTTOM    = 3'd3,
      REG_COL_PITCH = 3'd4,
      REG_ROW_PITCH = 3'd5,
      REG_COL_SCALE = 3'd6,
      REG_ROW_SCALE = 3'd7
   } csr_idx_type;

   // item kinds
   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_SAMPLE = 1'b1;

   // one pipeline stage word
   typedef struct packed {
      logic                     valid;
      logic                     action;
      logic [GIDX_W-1:0]        grow;
      logic [GIDX_W-1:0]        gcol;
      logic [GAIN_W-1:0]        gain;
      logic [POS_W-1:0]         pos_x;
      logic [POS_W-1:0]         pos_y;
      logic [SMP_W-1:0]         sample;
      logic                     inx;
      logic                     iny;
      logic [POS_W-1:0]         pitch_x;
      logic [POS_W-1:0]         pitch_y;
      logic [POS_W-1:0]         nx;
      logic [POS_W-1:0]         ny;
      logic [POS_W-1:0]         rx;
      logic [POS_W-1:0]         ry;
      logic [PROD_W-1:0]        prod_x;
      logic [PROD_W-1:0]        prod_y;
      logic [COL_W-1:0]         c0;
      logic [COL_W-1:0]         c1;
      logic [ROW_W-1:0]         r0;
      logic [ROW_W-1:0]         r1;
      logic [SCL_W-1:0]         wx;
      logic [SCL_W-1:0]         wy;
      logic [HOR_W-1:0]         hup;
      logic [HOR_W-1:0]         hlo;
      logic signed [PH_W-1:0]   ph;
      logic [PL_W-1:0]          pl;
      logic [G_W-1:0]           g;
      logic [MUL_W-1:0]         mul;
      logic [SMP_W-1:0]         res;
      logic                     clip;
   } stage_type;

endpackage

>>> rtl/core/raw_gm_ram.sv
// generic single write, single registered read memory, read-first
module raw_gm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/raw_gain_map_bilinear.sv
// Bilinear raw gain map: a gain grid held in memory applied to a raw sample stream.
// One word is taken every cycle, loads and samples alike, and a sample's result passes
// through an input register, a range and position stage, a 16-stage one-bit-per-stage
// remainder pipeline for the pitch lattice test and an output register; the grid
// arithmetic runs in parallel inside that depth. A load writes all four grid copies
// when it reaches the memory stage, the same stage where samples read their four
// neighbors, so a sample always sees every load taken before it. The whole pipeline holds
// while a result waits.
module raw_gain_map_bilinear (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: grid_row, grid_col, gain_word, pos_x, pos_y, sample_in, zero pad
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [raw_gm_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_tuser: action
   input  logic                                 req_tuser,
   // rsp_tdata: sample_out, gain_applied, clipped, zero pad
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [raw_gm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                                 csr_we,
   input  logic [raw_gm_pkg::CSR_A-1:0]         csr_addr,
   input  logic [raw_gm_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int NST = raw_gm_pkg::NST;
   localparam int POS_W = raw_gm_pkg::POS_W;
   localparam int SCL_W = raw_gm_pkg::SCL_W;
   localparam int ROW_W = raw_gm_pkg::ROW_W;
   localparam int COL_W = raw_gm_pkg::COL_W;
   localparam int ADDR_W = raw_gm_pkg::ADDR_W;
   localparam int GAIN_W = raw_gm_pkg::GAIN_W;
   localparam int HOR_W = raw_gm_pkg::HOR_W;
   localparam int SUM_W = raw_gm_pkg::SUM_W;
   localparam int MUL_W = raw_gm_pkg::MUL_W;
   localparam int SMP_W = raw_gm_pkg::SMP_W;
   localparam int DL_W = raw_gm_pkg::DL_W;
   localparam int DH_W = raw_gm_pkg::DH_W;
   localparam int G_W = raw_gm_pkg::G_W;
   localparam int RND_SH = raw_gm_pkg::RND_SH;
   localparam logic [COL_W-1:0] LAST_C = COL_W'(raw_gm_pkg::GRID_COLS - 1);
   localparam logic [ROW_W-1:0] LAST_R = ROW_W'(raw_gm_pkg::GRID_ROWS - 1);
   localparam logic [SCL_W:0] ONE = {1'b1, {SCL_W{1'b0}}};

   // configuration registers
   logic [POS_W-1:0] left_ff, right_ff, top_ff, bottom_ff, cpitch_ff, rpitch_ff;
   logic [SCL_W-1:0] cscale_ff, rscale_ff;

   raw_gm_pkg::stage_type st_ff [NST];
   raw_gm_pkg::stage_type st_in [NST];

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SMP_W-1:0]        out_smp_ff, out_smp_in;
   logic                    out_app_ff, out_app_in, out_clip_ff, out_clip_in;
   logic                    adv;

   // grid memory ports
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;
   logic [ADDR_W-1:0]       raddr [4];
   logic [GAIN_W-1:0]       rdata [4];

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         right_ff  <= '0;
         top_ff    <= '0;
         bottom_ff <= '0;
         cpitch_ff <= POS_W'(1);
         rpitch_ff <= POS_W'(1);
         cscale_ff <= '0;
         rscale_ff <= '0;
      end else if (csr_we) begin
         case (raw_gm_pkg::csr_idx_type'(csr_addr))
            raw_gm_pkg::REG_LEFT:      left_ff   <= csr_wdata[POS_W-1:0];
            raw_gm_pkg::REG_RIGHT:     right_ff  <= csr_wdata[POS_W-1:0];
            raw_gm_pkg::REG_TOP:       top_ff    <= csr_wdata[POS_W-1:0];
            raw_gm_pkg::REG_BOTTOM:    bottom_ff <= csr_wdata[POS_W-1:0];
            raw_gm_pkg::REG_COL_PITCH: cpitch_ff <= csr_wdata[POS_W-1:0];
            raw_gm_pkg::REG_ROW_PITCH: rpitch_ff <= csr_wdata[POS_W-1:0];
            raw_gm_pkg::REG_COL_SCALE: cscale_ff <= csr_wdata[SCL_W-1:0];
            raw_gm_pkg::REG_ROW_SCALE: rscale_ff <= csr_wdata[SCL_W-1:0];
            default: ;
         endcase
      end
   end

   // input word capture and per-stage work
   always_comb begin
      logic [POS_W:0]       rem_x, rem_y;
      logic [POS_W-1:0]     ipx, ipy;
      logic [HOR_W:0]       h0, h1;
      logic signed [HOR_W:0] diff;
      logic signed [SUM_W-1:0] vsum;
      logic [MUL_W-RND_SH:0] rnd;
      st_in[0]        = st_ff[0];
      st_in[0].valid  = req_tvalid;
      st_in[0].action = req_tuser;
      st_in[0].grow   = req_tdata[5:0];
      st_in[0].gcol   = req_tdata[11:6];
      st_in[0].gain   = req_tdata[27:12];
      st_in[0].pos_x  = req_tdata[43:28];
      st_in[0].pos_y  = req_tdata[59:44];
      st_in[0].sample = req_tdata[75:60];
      rem_x = '0;
      rem_y = '0;
      ipx   = '0;
      ipy   = '0;
      h0    = '0;
      h1    = '0;
      diff  = '0;
      vsum  = '0;
      rnd   = '0;
      for (int s = 1; s < NST; s++) begin
         st_in[s] = st_ff[s-1];
         rem_x = '0;
         rem_y = '0;
         ipx   = '0;
         ipy   = '0;
         h0    = '0;
         h1    = '0;
         diff  = '0;
         vsum  = '0;
         rnd   = '0;
         // range test, pitch, remainder init and grid position products
         if (s == 1) begin
            st_in[s].inx = (st_ff[0].pos_x >= left_ff) && (st_ff[0].pos_x < right_ff);
            st_in[s].iny = (st_ff[0].pos_y >= top_ff) && (st_ff[0].pos_y < bottom_ff);
            st_in[s].pitch_x = (cpitch_ff == '0) ? POS_W'(1) : cpitch_ff;
            st_in[s].pitch_y = (rpitch_ff == '0) ? POS_W'(1) : rpitch_ff;
            st_in[s].nx = st_ff[0].pos_x - left_ff;
            st_in[s].ny = st_ff[0].pos_y - top_ff;
            st_in[s].rx = '0;
            st_in[s].ry = '0;
            st_in[s].prod_x = st_ff[0].pos_x * cscale_ff;
            st_in[s].prod_y = st_ff[0].pos_y * rscale_ff;
         end
         // one remainder bit per stage
         if (s >= 2) begin
            rem_x = {st_ff[s-1].rx, st_ff[s-1].nx[POS_W-1]};
            rem_y = {st_ff[s-1].ry, st_ff[s-1].ny[POS_W-1]};
            if (rem_x >= {1'b0, st_ff[s-1].pitch_x}) rem_x = rem_x - {1'b0, st_ff[s-1].pitch_x};
            if (rem_y >= {1'b0, st_ff[s-1].pitch_y}) rem_y = rem_y - {1'b0, st_ff[s-1].pitch_y};
            st_in[s].rx = rem_x[POS_W-1:0];
            st_in[s].ry = rem_y[POS_W-1:0];
            st_in[s].nx = {st_ff[s-1].nx[POS_W-2:0], 1'b0};
            st_in[s].ny = {st_ff[s-1].ny[POS_W-2:0], 1'b0};
         end
         // cell index and weights, clamped at the last row and column
         if (s == 2) begin
            ipx = st_ff[1].prod_x[raw_gm_pkg::PROD_W-1:SCL_W];
            ipy = st_ff[1].prod_y[raw_gm_pkg::PROD_W-1:SCL_W];
            if (ipx >= POS_W'(LAST_C)) begin
               st_in[s].c0 = LAST_C;
               st_in[s].c1 = LAST_C;
               st_in[s].wx = '0;
            end else begin
               st_in[s].c0 = ipx[COL_W-1:0];
               st_in[s].c1 = ipx[COL_W-1:0] + COL_W'(1);
               st_in[s].wx = st_ff[1].prod_x[SCL_W-1:0];
            end
            if (ipy >= POS_W'(LAST_R)) begin
               st_in[s].r0 = LAST_R;
               st_in[s].r1 = LAST_R;
               st_in[s].wy = '0;
            end else begin
               st_in[s].r0 = ipy[ROW_W-1:0];
               st_in[s].r1 = ipy[ROW_W-1:0] + ROW_W'(1);
               st_in[s].wy = st_ff[1].prod_y[SCL_W-1:0];
            end
         end
         // horizontal interpolation on the four neighbors read from memory
         if (s == 4) begin
            h0 = (HOR_W+1)'(rdata[0] * (ONE - {1'b0, st_ff[3].wx}))
               + (HOR_W+1)'(rdata[1] * st_ff[3].wx);
            h1 = (HOR_W+1)'(rdata[2] * (ONE - {1'b0, st_ff[3].wx}))
               + (HOR_W+1)'(rdata[3] * st_ff[3].wx);
            st_in[s].hup = h0[HOR_W-1:0];
            st_in[s].hlo = h1[HOR_W-1:0];
         end
         // vertical step as row difference times weight, split in two products
         if (s == 5) begin
            diff = signed'({1'b0, st_ff[4].hlo}) - signed'({1'b0, st_ff[4].hup});
            st_in[s].ph = signed'(diff[HOR_W:DL_W]) * signed'({1'b0, st_ff[4].wy});
            st_in[s].pl = diff[DL_W-1:0] * st_ff[4].wy;
         end
         // gain with frac+16 fraction bits, rounded half up
         if (s == 6) begin
            vsum = signed'({2'b0, st_ff[5].hup, {SCL_W{1'b0}}})
                 + (signed'(SUM_W'(st_ff[5].ph)) <<< DL_W)
                 + signed'(SUM_W'(st_ff[5].pl))
                 + signed'(SUM_W'(64'h8000_0000));
            st_in[s].g = vsum[2*G_W-1:G_W];
         end
         if (s == 7) begin
            st_in[s].mul = st_ff[6].sample * st_ff[6].g;
         end
         // final rounding and saturation
         if (s == 8) begin
            rnd = (MUL_W-RND_SH+1)'((st_ff[7].mul + (MUL_W'(1) << (RND_SH-1))) >> RND_SH);
            if (rnd > (MUL_W-RND_SH+1)'(16'hFFFF)) begin
               st_in[s].res  = '1;
               st_in[s].clip = 1'b1;
            end else begin
               st_in[s].res  = rnd[SMP_W-1:0];
               st_in[s].clip = 1'b0;
            end
         end
      end
   end

   // grid memory: loads write and samples read at the same stage
   assign mem_we    = adv && st_ff[2].valid && (st_ff[2].action == raw_gm_pkg::ACT_LOAD)
                    && (32'(st_ff[2].grow) < 32'(raw_gm_pkg::GRID_ROWS))
                    && (32'(st_ff[2].gcol) < 32'(raw_gm_pkg::GRID_COLS));
   assign mem_waddr = ADDR_W'(ADDR_W'(st_ff[2].grow) * ADDR_W'(raw_gm_pkg::GRID_COLS)
                    + ADDR_W'(st_ff[2].gcol));
   assign raddr[0]  = ADDR_W'(ADDR_W'(st_ff[2].r0) * ADDR_W'(raw_gm_pkg::GRID_COLS)
                    + ADDR_W'(st_ff[2].c0));
   assign raddr[1]  = ADDR_W'(ADDR_W'(st_ff[2].r0) * ADDR_W'(raw_gm_pkg::GRID_COLS)
                    + ADDR_W'(st_ff[2].c1));
   assign raddr[2]  = ADDR_W'(ADDR_W'(st_ff[2].r1) * ADDR_W'(raw_gm_pkg::GRID_COLS)
                    + ADDR_W'(st_ff[2].c0));
   assign raddr[3]  = ADDR_W'(ADDR_W'(st_ff[2].r1) * ADDR_W'(raw_gm_pkg::GRID_COLS)
                    + ADDR_W'(st_ff[2].c1));

   for (genvar b = 0; b < 4; b++) begin : g_bank
      raw_gm_ram #(
         .WIDTH (GAIN_W),
         .DEPTH (raw_gm_pkg::DEPTH)
      ) u_grid (
         .clock (clock),
         .we    (mem_we),
         .waddr (mem_waddr),
         .wdata (st_ff[2].gain),
         .re    (adv),
         .raddr (raddr[b]),
         .rdata (rdata[b])
      );
   end

   // output word selection
   always_comb begin
      logic onlat;
      onlat = st_ff[NST-1].inx && st_ff[NST-1].iny
            && (st_ff[NST-1].rx == '0) && (st_ff[NST-1].ry == '0);
      rsp_valid_in = st_ff[NST-1].valid && (st_ff[NST-1].action == raw_gm_pkg::ACT_SAMPLE);
      out_smp_in   = onlat ? st_ff[NST-1].res : st_ff[NST-1].sample;
      out_app_in   = onlat;
      out_clip_in  = onlat && st_ff[NST-1].clip;
   end

   // pipeline and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NST; s++) begin
            st_ff[s].valid <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         for (int s = 0; s < NST; s++) begin
            st_ff[s] <= st_in[s];
         end
         rsp_valid_ff <= rsp_valid_in;
         out_smp_ff   <= out_smp_in;
         out_app_ff   <= out_app_in;
         out_clip_ff  <= out_clip_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, out_clip_ff, out_app_ff, out_smp_ff};

endmodule

>>> rtl/core/raw_gm_checker.sv
// port-level checks for the raw gain map, bound to the top level
module raw_gm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [raw_gm_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // no word leaves right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid after reset");

   // a held result keeps its word
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   // input is open whenever the output register is free
   a_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input closed with empty output");

   // a clipped result was gained and sits at full scale
   a_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17] |-> rsp_tdata[16] && (rsp_tdata[15:0] == 16'hFFFF))
      else $error("clipped flag without saturated gained word");

endmodule

bind raw_gain_map_bilinear raw_gm_checker u_raw_gm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
